>>> hdl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg: shared definitions of the pointer packet deframer
// Window geometry, frame byte codes, status bit masks and the result type.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned WinLen  = 9;
  localparam int unsigned FillW   = 4;
  localparam int unsigned ResultW = 23;
  localparam int unsigned TdataW  = 24;

  // frame bytes
  localparam logic [7:0] PfxCmd    = 8'h03;
  localparam logic [7:0] PfxData   = 8'h01;
  localparam logic [7:0] PfxAll    = 8'hFF;
  localparam logic [7:0] SuffixDot = 8'h2E;

  // status byte bits
  localparam logic [7:0] StSkipBit  = 8'h08;
  localparam logic [7:0] StSkipMask = 8'hC0;
  localparam logic [7:0] StMiddle   = 8'h04;
  localparam logic [7:0] StBoth     = 8'h03;
  localparam logic [7:0] StRight    = 8'h02;
  localparam logic [7:0] StLeft     = 8'h01;

  // status bit positions for the sign extensions
  localparam int unsigned StXSignPos = 4;
  localparam int unsigned StYSignPos = 5;

  typedef enum logic [2:0] {
    BTN_NONE   = 3'd0,
    BTN_MIDDLE = 3'd1,
    BTN_DOUBLE = 3'd2,
    BTN_RIGHT  = 3'd3,
    BTN_LEFT   = 3'd4
  } ppd_button_e;

  // packed MSB first: button_action lands in the lowest bits
  typedef struct packed {
    logic signed [9:0] delta_y;
    logic signed [8:0] delta_x;
    logic              text_lock;
    ppd_button_e       button_action;
  } ppd_result_t;

  function automatic logic prefix_ok(input logic [7:0] b);
    prefix_ok = (b == PfxCmd) || (b == PfxData) || (b == PfxAll);
  endfunction

endpackage

>>> hdl/ppd_window.sv
// ----------------------------------------------------------------------------
// ppd_window: byte window and packet decode
// Stores one byte per step, checks the full window and slides or decodes it.
// ----------------------------------------------------------------------------
module ppd_window import ppd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output logic        res_valid_o,
  output ppd_result_t res_o
);

  logic [7:0]       win_q [WinLen];
  logic [7:0]       win_d [WinLen];
  logic [7:0]       win_w [WinLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic             full;
  logic             frame_ok;
  logic             skip;
  logic [7:0]       st;
  logic [7:0]       px;
  logic [7:0]       py;

  // window with the new byte written at the fill point
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      win_w[i] = (fill_q == FillW'(i)) ? byte_i : win_q[i];
    end
  end

  assign full = (fill_q == FillW'(WinLen - 1));

  always_comb begin
    frame_ok = 1'b1;
    for (int t = 0; t < 3; t++) begin
      if (!prefix_ok(win_w[3*t]) || (win_w[3*t+2] != SuffixDot)) begin
        frame_ok = 1'b0;
      end
    end
  end

  assign st   = win_w[1];
  assign px   = win_w[4];
  assign py   = win_w[7];
  assign skip = ((st & StSkipBit) != 8'h00) && ((st & StSkipMask) == 8'h00);

  assign res_valid_o = step_i && full && frame_ok && !skip;

  always_comb begin
    win_d  = win_w;
    fill_d = fill_q + FillW'(1);
    if (full) begin
      if (!frame_ok) begin
        for (int i = 0; i < WinLen - 1; i++) begin
          win_d[i] = win_w[i+1];
        end
        fill_d = FillW'(WinLen - 1);
      end else if (skip) begin
        for (int i = 0; i < WinLen - 3; i++) begin
          win_d[i] = win_w[i+3];
        end
        fill_d = FillW'(WinLen - 3);
      end else begin
        // accepted: later bytes start a fresh window
        fill_d = '0;
      end
    end
  end

  always_comb begin
    if ((st & StMiddle) != 8'h00) begin
      res_o.button_action = BTN_MIDDLE;
    end else if ((st & StBoth) == StBoth) begin
      res_o.button_action = BTN_DOUBLE;
    end else if ((st & StRight) != 8'h00) begin
      res_o.button_action = BTN_RIGHT;
    end else if ((st & StLeft) != 8'h00) begin
      res_o.button_action = BTN_LEFT;
    end else begin
      res_o.button_action = BTN_NONE;
    end
    res_o.text_lock = (st & StMiddle) != 8'h00;
    res_o.delta_x   = {st[StXSignPos], px};
    res_o.delta_y   = 10'd0 - {2'b00, py} + {1'b0, st[StYSignPos], 8'h00};
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step_i) begin
      fill_q <= fill_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WinLen - 1))
    else $error("window fill past last slot");

  a_res_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (fill_q == FillW'(WinLen - 1)))
    else $error("result from a partial window");

  a_res_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (fill_q == '0))
    else $error("window not restarted after packet");
`endif

endmodule

>>> hdl/ppd_out_reg.sv
// ----------------------------------------------------------------------------
// ppd_out_reg: result register
// Holds one decoded packet until the downstream transfer completes.
// ----------------------------------------------------------------------------
module ppd_out_reg import ppd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ppd_result_t res_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output ppd_result_t res_o
);

  logic        valid_q, valid_d;
  ppd_result_t res_q;

  // free when empty or draining this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hdl/pointer_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// pointer_packet_deframer_unit: pointer device packet deframer
// Frames serial bytes into 9-byte packets and emits decoded pointer results.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer, one transfer per clock cycle when the
// output side keeps up. Bytes are gathered in a 9-byte window of three
// prefix/payload/period triplets. A full window with a bad prefix or period
// slides by one byte; one whose status byte has bit 3 set and bits 7:6 clear
// slides by a triplet; any other full window yields one result with the
// button action, text lock flag and signed X/Y deltas (Y negated). The last
// packet byte passes through the input register, then the window decode,
// which is combinational and loads the result register that drives the
// master side. Back pressure from m_axis stalls the input register only when
// the result register is still occupied.
module pointer_packet_deframer_unit import ppd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] rx_byte
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o    // [2:0] button_action, [3] text_lock,
                                              // [12:4] delta_x, [22:13] delta_y
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_free;
  logic        step;
  logic        res_valid;
  ppd_result_t res;
  ppd_result_t out_res;

  // the held byte moves into the window whenever the result slot can take it
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (step) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  ppd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ppd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  // pad to whole bytes
  assign m_axis_tdata_o = {{(TdataW - ResultW){1'b0}}, out_res};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a blocked result");
`endif

endmodule
